>>> rtl/core/shcf_pkg.sv
// Shared types and constants of the strip hit cluster finder.
// No dependencies; compile first.
package shcf_pkg;

	// Readout geometry: strips per chip and chips per front end.
	localparam int unsigned STRIPS_PER_CHIP = 254;
	localparam int unsigned CHIPS           = 8;

	localparam int unsigned WIDTH_W   = 12;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

	typedef struct packed {
		logic [3:0] front_end;
		logic       layer;
		logic [3:0] chip;
		logic [7:0] strip;
		logic       hit;
		logic       end_of_layer;
	} hit_item_t;

	typedef struct packed {
		logic [3:0]         cluster_front_end;
		logic               cluster_layer;
		logic [3:0]         start_chip;
		logic [7:0]         start_strip;
		logic [WIDTH_W-1:0] cluster_width;
	} cluster_t;

	// Run tracker status for one processed item.
	typedef struct packed {
		logic     emit;
		cluster_t cluster;
	} trk_res_t;

endpackage

>>> rtl/core/shcf_ifs.sv
// Valid/ready channel interfaces of the strip hit cluster finder.
// Depends on nothing; the payload widths follow shcf_pkg field widths.
interface shcf_hit_if;
	logic       valid;
	logic       ready;
	logic [3:0] front_end;
	logic       layer;
	logic [3:0] chip;
	logic [7:0] strip;
	logic       hit;
	logic       end_of_layer;

	modport source (output valid, front_end, layer, chip, strip, hit, end_of_layer,
		input ready);
	modport sink (input valid, front_end, layer, chip, strip, hit, end_of_layer,
		output ready);
endinterface

interface shcf_cluster_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cluster_front_end;
	logic        cluster_layer;
	logic [3:0]  start_chip;
	logic [7:0]  start_strip;
	logic [11:0] cluster_width;

	modport source (output valid, cluster_front_end, cluster_layer, start_chip,
		start_strip, cluster_width, input ready);
	modport sink (input valid, cluster_front_end, cluster_layer, start_chip,
		start_strip, cluster_width, output ready);
endinterface

>>> rtl/core/shcf_run_tracker.sv
// Run tracker: open-run state and the cluster decision for one strip item.
// Depends on shcf_pkg.
module shcf_run_tracker import shcf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  hit_item_t item,
	output trk_res_t  res
);

	logic               in_run_q;
	logic [3:0]         run_chip_q;
	logic [7:0]         run_strip_q;
	logic [WIDTH_W-1:0] run_width_q;

	logic               chip_ok;
	logic               strip_ok;
	logic               hit_ok;
	logic               clear_run;
	logic [3:0]         nxt_chip;
	logic [7:0]         nxt_strip;
	logic [WIDTH_W-1:0] nxt_width;

	// out-of-range strips count as non-fired
	assign chip_ok  = {1'b0, item.chip} < 5'(CHIPS);
	assign strip_ok = {1'b0, item.strip} < 9'(STRIPS_PER_CHIP);
	assign hit_ok   = item.hit && chip_ok && strip_ok;

	always_comb begin
		nxt_chip  = run_chip_q;
		nxt_strip = run_strip_q;
		nxt_width = run_width_q;
		res.emit  = 1'b0;
		if (hit_ok) begin
			if (!in_run_q) begin
				nxt_chip  = item.chip;
				nxt_strip = item.strip;
				nxt_width = WIDTH_W'(1);
			end else if (run_width_q != WIDTH_MAX) begin
				nxt_width = run_width_q + WIDTH_W'(1);
			end
			res.emit = item.end_of_layer;
		end else begin
			res.emit = in_run_q;
		end
		res.cluster.cluster_front_end = item.front_end;
		res.cluster.cluster_layer     = item.layer;
		res.cluster.start_chip        = nxt_chip;
		res.cluster.start_strip       = nxt_strip;
		res.cluster.cluster_width     = nxt_width;
	end

	assign clear_run = res.emit || item.end_of_layer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			run_chip_q  <= '0;
			run_strip_q <= '0;
			run_width_q <= '0;
		end else if (step) begin
			if (clear_run) begin
				in_run_q    <= 1'b0;
				run_chip_q  <= '0;
				run_strip_q <= '0;
				run_width_q <= '0;
			end else if (hit_ok) begin
				in_run_q    <= 1'b1;
				run_chip_q  <= nxt_chip;
				run_strip_q <= nxt_strip;
				run_width_q <= nxt_width;
			end
		end
	end

endmodule

>>> rtl/core/strip_hit_cluster_finder_top.sv
// Top level of the strip hit cluster finder.
// Depends on shcf_pkg, shcf_ifs (channel interfaces) and shcf_run_tracker.
//
// Usage:
//   hits     : sink channel, one strip bit per request, ordered by layer,
//              chip, then strip. end_of_layer marks the layer's last strip.
//   clusters : source channel, one request per finished cluster: closing
//              item's front end and layer, start chip, start strip, width.
//   A run of fired strips is one cluster, even across chip boundaries. It
//   closes on the first non-fired strip, or on the layer's last strip; the
//   layer's last strip always clears the tracker, so layers never merge.
//   Strips outside CHIPS x STRIPS_PER_CHIP read as non-fired. Width
//   saturates at 4095.
// Timing:
//   Input register (_s1), then the tracker logic, then the output register.
//   The closing request is held in _s1, then its cluster in the output register.
//   One request per cycle is taken, sustained, unless clusters stalls.
// Reset:
//   arst_n clears the pipeline valids and the run tracker; no run is open.
// Stall:
//   While clusters.ready is low with a cluster pending, the input register
//   holds and hits.ready drops once it is full; nothing is lost or repeated.
module strip_hit_cluster_finder_top import shcf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	shcf_hit_if.sink       hits,
	shcf_cluster_if.source clusters
);

	hit_item_t item_s1;
	logic      valid_s1_q;
	cluster_t  cluster_q;
	logic      out_valid_q;
	logic      advance;
	logic      step;
	trk_res_t  trk_res;

	// The input stage moves whenever the output register is free or emptying.
	assign advance     = !out_valid_q || clusters.ready;
	assign hits.ready  = !valid_s1_q || advance;
	assign step        = valid_s1_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (hits.ready) begin
			valid_s1_q <= hits.valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (hits.ready && hits.valid) begin
			item_s1.front_end    <= hits.front_end;
			item_s1.layer        <= hits.layer;
			item_s1.chip         <= hits.chip;
			item_s1.strip        <= hits.strip;
			item_s1.hit          <= hits.hit;
			item_s1.end_of_layer <= hits.end_of_layer;
		end
	end

	shcf_run_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (trk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && trk_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && trk_res.emit) begin
			cluster_q <= trk_res.cluster;
		end
	end

	assign clusters.valid             = out_valid_q;
	assign clusters.cluster_front_end = cluster_q.cluster_front_end;
	assign clusters.cluster_layer     = cluster_q.cluster_layer;
	assign clusters.start_chip        = cluster_q.start_chip;
	assign clusters.start_strip       = cluster_q.start_strip;
	assign clusters.cluster_width     = cluster_q.cluster_width;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for strip_hit_cluster_finder_top: queued strip scans, random idling.
// Depends on shcf_pkg, shcf_ifs and the RTL of the cluster finder.
module testbench;
	import shcf_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1200;
	localparam int ITEM_W = $bits(hit_item_t);

	logic clk;
	logic arst_n;

	shcf_hit_if hits_ch();
	shcf_cluster_if clus_ch();

	strip_hit_cluster_finder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.hits     (hits_ch),
		.clusters (clus_ch)
	);

	hit_item_t strip_queue[$];
	cluster_t  cluster_queue[$];
	int        error_count = 0;
	int        cluster_count = 0;

	// Run tracker copy used for prediction
	bit                 run_open = 1'b0;
	logic [3:0]         run_chip = '0;
	logic [7:0]         run_strip = '0;
	logic [WIDTH_W-1:0] run_count = '0;

	always #4 clk = ~clk;

	function automatic hit_item_t mk(int fe, int ly, int ch, int st, int h, int eol);
		hit_item_t it;
		it.front_end    = fe[3:0];
		it.layer        = ly[0];
		it.chip         = ch[3:0];
		it.strip        = st[7:0];
		it.hit          = h[0];
		it.end_of_layer = eol[0];
		return it;
	endfunction

	// Gap length: mostly zero or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Advances the tracker by one strip; returns 1 when a cluster closes.
	function automatic bit track_strip(input hit_item_t it, output cluster_t cl);
		bit fired;
		bit emit;
		fired = it.hit && (it.chip < CHIPS) && (it.strip < STRIPS_PER_CHIP);
		emit = 1'b0;
		if (fired) begin
			if (!run_open) begin
				run_open  = 1'b1;
				run_chip  = it.chip;
				run_strip = it.strip;
				run_count = '0;
			end
			if (run_count != WIDTH_MAX)
				run_count = run_count + 1'b1;
			if (it.end_of_layer)
				emit = 1'b1;
		end else if (run_open) begin
			emit = 1'b1;
		end
		cl.cluster_front_end = it.front_end;
		cl.cluster_layer     = it.layer;
		cl.start_chip        = run_chip;
		cl.start_strip       = run_strip;
		cl.cluster_width     = run_count;
		if (emit || it.end_of_layer) begin
			run_open  = 1'b0;
			run_chip  = '0;
			run_strip = '0;
			run_count = '0;
		end
		return emit;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
		$display("MISMATCH %s: got %0d expected %0d (cluster %0d)", what, got, exp,
			cluster_count);
		error_count++;
	endtask

	// Appends one strip request to the pending queue
	task automatic add_strip(input hit_item_t it);
		strip_queue = {strip_queue, it};
	endtask

	// Request driver
	int        src_gap = 0;
	int        src_free = 0;
	hit_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_ch.valid        <= 1'b0;
			hits_ch.front_end    <= '0;
			hits_ch.layer        <= 1'b0;
			hits_ch.chip         <= '0;
			hits_ch.strip        <= '0;
			hits_ch.hit          <= 1'b0;
			hits_ch.end_of_layer <= 1'b0;
			src_gap = 0;
		end else if (!hits_ch.valid || hits_ch.ready) begin
			if (src_gap > 0) begin
				src_gap--;
				hits_ch.valid <= 1'b0;
			end else if (strip_queue.size() != 0) begin
				drv_item = strip_queue.pop_front();
				hits_ch.valid        <= 1'b1;
				hits_ch.front_end    <= drv_item.front_end;
				hits_ch.layer        <= drv_item.layer;
				hits_ch.chip         <= drv_item.chip;
				hits_ch.strip        <= drv_item.strip;
				hits_ch.hit          <= drv_item.hit;
				hits_ch.end_of_layer <= drv_item.end_of_layer;
				if (src_free > 0)
					src_free--;
				else if ($urandom_range(0, 99) < 2)
					src_free = $urandom_range(50, 200);
				else
					src_gap = pick_gap();
			end else begin
				hits_ch.valid <= 1'b0;
			end
		end
	end

	// Back-pressure on the cluster side
	int snk_hold = 0;
	int snk_free = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clus_ch.ready <= 1'b0;
			snk_hold = 0;
		end else if (snk_hold > 0) begin
			snk_hold--;
			clus_ch.ready <= 1'b0;
		end else begin
			clus_ch.ready <= 1'b1;
			if (snk_free > 0)
				snk_free--;
			else if ($urandom_range(0, 99) < 2)
				snk_free = $urandom_range(50, 200);
			else
				snk_hold = pick_gap();
		end
	end

	// Monitors: predict on accepted strips, check accepted clusters
	hit_item_t acc_item;
	cluster_t  pred_cl;
	cluster_t  exp_cl;
	cluster_t  got_cl;

	always @(posedge clk) begin
		if (arst_n && hits_ch.valid && hits_ch.ready) begin
			acc_item = mk(hits_ch.front_end, hits_ch.layer, hits_ch.chip, hits_ch.strip,
				hits_ch.hit, hits_ch.end_of_layer);
			if (track_strip(acc_item, pred_cl))
				cluster_queue = {cluster_queue, pred_cl};
		end
	end

	always @(posedge clk) begin
		if (arst_n && clus_ch.valid && clus_ch.ready) begin
			got_cl.cluster_front_end = clus_ch.cluster_front_end;
			got_cl.cluster_layer     = clus_ch.cluster_layer;
			got_cl.start_chip        = clus_ch.start_chip;
			got_cl.start_strip       = clus_ch.start_strip;
			got_cl.cluster_width     = clus_ch.cluster_width;
			if (cluster_queue.size() == 0) begin
				report_mismatch("unexpected cluster, width", got_cl.cluster_width, 0);
			end else begin
				exp_cl = cluster_queue.pop_front();
				if (got_cl.cluster_front_end !== exp_cl.cluster_front_end)
					report_mismatch("front_end", got_cl.cluster_front_end,
						exp_cl.cluster_front_end);
				if (got_cl.cluster_layer !== exp_cl.cluster_layer)
					report_mismatch("layer", got_cl.cluster_layer, exp_cl.cluster_layer);
				if (got_cl.start_chip !== exp_cl.start_chip)
					report_mismatch("start_chip", got_cl.start_chip, exp_cl.start_chip);
				if (got_cl.start_strip !== exp_cl.start_strip)
					report_mismatch("start_strip", got_cl.start_strip, exp_cl.start_strip);
				if (got_cl.cluster_width !== exp_cl.cluster_width)
					report_mismatch("width", got_cl.cluster_width, exp_cl.cluster_width);
			end
			cluster_count++;
		end
	end

	// Watchdog: cycles with no handshake on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((hits_ch.valid && hits_ch.ready) || (clus_ch.valid && clus_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int        made;
		int        fe, ly, ch, st, n, dens, k;
		bit        on, last, eol;
		hit_item_t it;

		clk = 1'b0;
		arst_n = 1'b0;

		// Directed: single hit, chip crossing, out-of-range strips and chips,
		// fired last strip, empty layer end, mixed front ends within a run.
		add_strip(mk(0, 0, 0, 0, 1, 0));
		add_strip(mk(0, 0, 0, 1, 0, 0));
		add_strip(mk(1, 0, 0, 252, 1, 0));
		add_strip(mk(1, 0, 0, 253, 1, 0));
		add_strip(mk(1, 0, 1, 0, 1, 0));
		add_strip(mk(1, 0, 1, 1, 0, 0));
		add_strip(mk(2, 1, 2, 253, 1, 0));
		add_strip(mk(2, 1, 2, 254, 1, 0));
		add_strip(mk(2, 1, 2, 255, 1, 0));
		add_strip(mk(2, 1, 8, 0, 1, 0));
		add_strip(mk(2, 1, 15, 255, 1, 0));
		add_strip(mk(3, 0, 7, 253, 1, 1));
		add_strip(mk(3, 0, 7, 252, 1, 0));
		add_strip(mk(3, 0, 7, 253, 1, 1));
		add_strip(mk(4, 1, 7, 253, 0, 1));
		add_strip(mk(4, 1, 5, 10, 1, 0));
		add_strip(mk(4, 1, 5, 11, 0, 1));
		add_strip(mk(6, 0, 3, 100, 1, 0));
		add_strip(mk(6, 0, 9, 0, 1, 1));
		add_strip(mk(3, 0, 4, 7, 1, 0));
		add_strip(mk(9, 1, 4, 8, 1, 0));
		add_strip(mk(12, 1, 4, 9, 0, 0));
		add_strip(mk(15, 1, 7, 255, 1, 1));
		add_strip(mk(15, 1, 0, 0, 0, 1));

		// Random: mostly ordered scan segments, some raw noise.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 15) begin
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++) begin
					it = ITEM_W'($urandom);
					add_strip(it);
				end
				made += n;
			end else begin
				fe = $urandom_range(0, 15);
				ly = $urandom_range(0, 1);
				ch = $urandom_range(0, CHIPS - 1);
				st = $urandom_range(0, STRIPS_PER_CHIP - 1);
				if ($urandom_range(0, 3) == 0) begin
					// segment starting near the real last strip of the layer; it stops there at the latest
					ch = CHIPS - 1;
					st = STRIPS_PER_CHIP - $urandom_range(1, 40);
				end
				n = $urandom_range(4, 60);
				case ($urandom_range(0, 2))
					0: dens = 15;
					1: dens = 50;
					default: dens = 85;
				endcase
				on = 1'b0;
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 99) < 35)
						on = ($urandom_range(0, 99) < dens);
					last = (k == n - 1) ||
						(ch == CHIPS - 1 && st == STRIPS_PER_CHIP - 1);
					eol = last ? ($urandom_range(0, 9) != 0) : 1'b0;
					it = mk(fe, ly, ch, st, on, eol);
					if ($urandom_range(0, 49) == 0)
						it.strip = 8'($urandom_range(STRIPS_PER_CHIP, 255));
					else if ($urandom_range(0, 49) == 0)
						it.chip = 4'($urandom_range(CHIPS, 15));
					add_strip(it);
					made++;
					if (last)
						break;
					st++;
					if (st == STRIPS_PER_CHIP) begin
						st = 0;
						ch++;
					end
				end
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (strip_queue.size() != 0 || hits_ch.valid)
			@(posedge clk);
		while (cluster_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
